// ----- rtl/i2cebm_pkg.sv -----
`timescale 1ns / 1ps

package i2cebm_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Configuration register indexes (byte address 4 * index).
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd20;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;

    // Device select byte of a 24C04; bit 1 is the block bit, bit 0 the read flag.
    localparam logic [7:0] DEV_BASE = 8'hA0;

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] mem_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } res_t;

    typedef struct packed {
        logic [7:0]  half_period;
        logic [15:0] ack_timeout;
    } cfg_t;

    // Bus sub-sequences that make up a transaction.
    typedef enum logic [2:0] {
        SUB_START = 3'd0,
        SUB_WB    = 3'd1,
        SUB_RB    = 3'd2,
        SUB_NOACK = 3'd3,
        SUB_STOP  = 3'd4,
        SUB_END   = 3'd5
    } sub_e_t;

    // Where a written byte comes from.
    typedef enum logic [1:0] {
        SRC_DEV  = 2'd0,
        SRC_DEVR = 2'd1,
        SRC_ADDR = 2'd2,
        SRC_DATA = 2'd3
    } src_e_t;

    typedef struct packed {
        sub_e_t sub;
        src_e_t src;
    } macro_t;

    // One state per bus delay or ack poll the sequencer can rest on.
    typedef enum logic [21:0] {
        ST_IDLE      = 22'h000001,
        ST_STA_0     = 22'h000002,
        ST_STA_1     = 22'h000004,
        ST_STA_2     = 22'h000008,
        ST_STA_3     = 22'h000010,
        ST_WB_BIT_LO = 22'h000020,
        ST_WB_BIT_HI = 22'h000040,
        ST_WB_ACK_0  = 22'h000080,
        ST_WB_ACK_1  = 22'h000100,
        ST_WB_ACK_2  = 22'h000200,
        ST_WB_ACK_3  = 22'h000400,
        ST_WB_POLL   = 22'h000800,
        ST_RB_HI_0   = 22'h001000,
        ST_RB_HI_1   = 22'h002000,
        ST_RB_LO     = 22'h004000,
        ST_NAK_0     = 22'h008000,
        ST_NAK_1     = 22'h010000,
        ST_NAK_2     = 22'h020000,
        ST_STO_0     = 22'h040000,
        ST_STO_1     = 22'h080000,
        ST_STO_2     = 22'h100000,
        ST_STO_3     = 22'h200000
    } st_e_t;

    // Transaction programs: the sub-sequence run at each step.
    function automatic macro_t prog_step(input logic is_rd, input logic [3:0] step);
        macro_t m;
        m.sub = SUB_END;
        m.src = SRC_DEV;
        if (is_rd)
        begin
            case (step)
                4'd0:    m.sub = SUB_START;
                4'd1:    begin m.sub = SUB_WB; m.src = SRC_DEV;  end
                4'd2:    begin m.sub = SUB_WB; m.src = SRC_ADDR; end
                4'd3:    m.sub = SUB_START;
                4'd4:    begin m.sub = SUB_WB; m.src = SRC_DEVR; end
                4'd5:    m.sub = SUB_RB;
                4'd6:    m.sub = SUB_NOACK;
                4'd7:    m.sub = SUB_STOP;
                default: m.sub = SUB_END;
            endcase
        end
        else
        begin
            case (step)
                4'd0:    m.sub = SUB_START;
                4'd1:    begin m.sub = SUB_WB; m.src = SRC_DEV;  end
                4'd2:    begin m.sub = SUB_WB; m.src = SRC_ADDR; end
                4'd3:    begin m.sub = SUB_WB; m.src = SRC_DATA; end
                4'd4:    m.sub = SUB_STOP;
                default: m.sub = SUB_END;
            endcase
        end
        return m;
    endfunction

    function automatic logic [7:0] src_byte(input src_e_t src, input logic [8:0] addr,
                                            input logic [7:0] data);
        logic [7:0] dev;
        dev = DEV_BASE | {6'd0, addr[8], 1'b0};
        case (src)
            SRC_DEV:  return dev;
            SRC_DEVR: return dev | 8'h01;
            SRC_ADDR: return addr[7:0];
            default:  return data;
        endcase
    endfunction

endpackage

// ----- rtl/i2cebm_cfg.sv -----
`timescale 1ns / 1ps

module i2cebm_cfg
    import i2cebm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [7:0]  half_period_reg;
    logic [15:0] ack_timeout_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_HALF_PERIOD)
            begin
                half_period_reg <= pwdata[7:0];
            end
            else
            begin
                ack_timeout_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_HALF_PERIOD)
        begin
            prdata = {24'd0, half_period_reg};
        end
        else
        begin
            prdata = {16'd0, ack_timeout_reg};
        end
    end

    assign cfg.half_period = half_period_reg;
    assign cfg.ack_timeout = ack_timeout_reg;

endmodule

// ----- rtl/i2cebm_seq.sv -----
`timescale 1ns / 1ps

module i2cebm_seq
    import i2cebm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    st_e_t       state_reg, state_next, tgt;
    logic        post_reg, post_next;
    logic [7:0]  phase_reg, phase_next, phase_p, phase_inc;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [8:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic        rd_reg, rd_next;
    logic [15:0] wait_reg, wait_next, wait_p;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [3:0]  macro_reg, macro_next, ent_step;
    logic        ent;
    logic        finish;
    macro_t      m;

    always_comb
    begin
        // Level changes that happen before the next delay or poll.
        tgt        = state_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        wait_p     = wait_reg;
        phase_p    = phase_reg;
        macro_next = macro_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        rd_next    = rd_reg;
        ent        = 1'b0;
        ent_step   = 4'(macro_reg + 4'd1);
        finish     = 1'b0;
        m.sub      = SUB_END;
        m.src      = SRC_DEV;

        if (state_reg == ST_IDLE)
        begin
            if (item.req_type == REQ_READ || item.req_type == REQ_WRITE)
            begin
                addr_next = item.mem_addr;
                data_next = item.write_data;
                rd_next   = (item.req_type == REQ_READ);
                phase_p   = 8'd0;
                bit_next  = 3'd0;
                wait_p    = 16'd0;
                ent       = 1'b1;
                ent_step  = 4'd0;
            end
        end
        else if (post_reg)
        begin
            case (state_reg)
                ST_STA_0:     begin scl_next = 1'b1; tgt = ST_STA_1; end
                ST_STA_1:     begin sda_next = 1'b0; tgt = ST_STA_2; end
                ST_STA_2:     begin scl_next = 1'b0; tgt = ST_STA_3; end
                ST_STA_3:     begin sda_next = 1'b1; ent = 1'b1; end
                ST_WB_BIT_LO:
                begin
                    sda_next   = shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    scl_next   = 1'b1;
                    tgt        = ST_WB_BIT_HI;
                end
                ST_WB_BIT_HI:
                begin
                    scl_next = 1'b0;
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = 3'd0;
                        tgt      = ST_WB_ACK_0;
                    end
                    else
                    begin
                        bit_next = 3'(bit_reg + 3'd1);
                        tgt      = ST_WB_BIT_LO;
                    end
                end
                ST_WB_ACK_0:  begin sda_next = 1'b1; tgt = ST_WB_ACK_1; end
                ST_WB_ACK_1:  begin scl_next = 1'b1; tgt = ST_WB_ACK_2; end
                ST_WB_ACK_2:
                begin
                    scl_next = 1'b0;
                    wait_p   = cfg.ack_timeout;
                    tgt      = ST_WB_ACK_3;
                end
                ST_WB_ACK_3:
                begin
                    // A zero timeout skips the ack poll altogether.
                    if (wait_reg == 16'd0)
                    begin
                        ent = 1'b1;
                    end
                    else
                    begin
                        tgt = ST_WB_POLL;
                    end
                end
                ST_WB_POLL:   ent = 1'b1;
                ST_RB_HI_0:
                begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    tgt        = ST_RB_HI_1;
                end
                ST_RB_HI_1:   begin scl_next = 1'b0; tgt = ST_RB_LO; end
                ST_RB_LO:
                begin
                    if (bit_reg == 3'd7)
                    begin
                        bit_next = 3'd0;
                        ent      = 1'b1;
                    end
                    else
                    begin
                        bit_next = 3'(bit_reg + 3'd1);
                        scl_next = 1'b1;
                        tgt      = ST_RB_HI_0;
                    end
                end
                ST_NAK_0:     begin scl_next = 1'b1; tgt = ST_NAK_1; end
                ST_NAK_1:     begin scl_next = 1'b0; tgt = ST_NAK_2; end
                ST_NAK_2:     ent = 1'b1;
                ST_STO_0:     begin sda_next = 1'b0; tgt = ST_STO_1; end
                ST_STO_1:     begin scl_next = 1'b1; tgt = ST_STO_2; end
                ST_STO_2:     begin sda_next = 1'b1; tgt = ST_STO_3; end
                ST_STO_3:     begin scl_next = 1'b0; ent = 1'b1; end
                default:      tgt = state_reg;
            endcase
        end

        // Entering the next sub-sequence up to its first delay.
        if (ent)
        begin
            macro_next = ent_step;
            m          = prog_step(rd_next, ent_step);
            case (m.sub)
                SUB_START:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    tgt      = ST_STA_0;
                end
                SUB_WB:
                begin
                    shift_next = src_byte(m.src, addr_next, data_next);
                    bit_next   = 3'd0;
                    scl_next   = 1'b0;
                    tgt        = ST_WB_BIT_LO;
                end
                SUB_RB:
                begin
                    shift_next = 8'd0;
                    bit_next   = 3'd0;
                    scl_next   = 1'b1;
                    tgt        = ST_RB_HI_0;
                end
                SUB_NOACK:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    tgt      = ST_NAK_0;
                end
                SUB_STOP:
                begin
                    scl_next = 1'b0;
                    tgt      = ST_STO_0;
                end
                default:
                begin
                    finish = 1'b1;
                    tgt    = ST_IDLE;
                end
            endcase
        end

        // One tick of the delay or poll the sequencer now rests on.
        state_next = tgt;
        post_next  = 1'b0;
        phase_next = phase_p;
        wait_next  = wait_p;
        phase_inc  = 8'(phase_p + 8'd1);
        if (finish || tgt == ST_IDLE)
        begin
            state_next = ST_IDLE;
        end
        else if (tgt == ST_WB_POLL)
        begin
            if (item.sda_in)
            begin
                post_next = 1'b1;
            end
            else
            begin
                wait_next = 16'(wait_p - 16'd1);
                post_next = (wait_p == 16'd1);
            end
        end
        else if (phase_inc >= cfg.half_period)
        begin
            phase_next = 8'd0;
            post_next  = 1'b1;
        end
        else
        begin
            phase_next = phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            post_reg  <= 1'b0;
            phase_reg <= 8'd0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'd0;
            addr_reg  <= 9'd0;
            data_reg  <= 8'd0;
            rd_reg    <= 1'b0;
            wait_reg  <= 16'd0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b1;
            macro_reg <= 4'd0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            rd_reg    <= rd_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            macro_reg <= macro_next;
        end
    end

    assign res.scl_level = scl_next;
    assign res.sda_level = sda_next;
    assign res.busy_res  = (state_next != ST_IDLE);
    assign res.done_res  = finish;
    assign res.read_data = (finish && rd_next) ? shift_next : 8'd0;

endmodule

// ----- rtl/i2c_eeprom_byte_master_core.sv -----
`timescale 1ns / 1ps
// Path: a request is held in the input register; when the result register is free or
// draining, it steps the sequencer and its result is loaded into the result register.
// Throughput: one request per clock cycle while the result register is free or draining.
// Reset (rst_n low, asynchronous): the sequencer goes idle with SCL low and SDA released,
// and half_period and ack_timeout return to 20 and 5000.
module i2c_eeprom_byte_master_core
    import i2cebm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,

    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    // Every request is one tick of the bus sequencer. It first lands in the input
    // register. When the result register is empty, or is being emptied in the same
    // cycle, the held request steps the sequencer and its levels go to the result
    // register. One request can wait on each side of the sequencer: new requests are
    // taken every cycle while results drain, and one more while a result waits.

    cfg_t  cfg;
    logic  hold_valid_reg;
    item_t hold_item_reg;
    logic  res_valid_reg;
    res_t  res_data_reg;
    res_t  seq_res;
    logic  res_free;
    logic  step_en;

    i2cebm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result slot can take a new result when it is empty or draining now.
    assign res_free   = !res_valid_reg || res_ready;
    // The held request advances the sequencer only when its result has a place to go.
    assign step_en    = hold_valid_reg && res_free;
    assign item_ready = !hold_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            hold_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            hold_item_reg <= item;
        end
    end

    i2cebm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (hold_item_reg),
        .cfg     (cfg),
        .res     (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= hold_valid_reg;
        end
    end

    // Result payload is only loaded when a request steps the sequencer.
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_data_reg <= seq_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

endmodule

// ----- rtl/i2cebm_checker.sv -----
`timescale 1ns / 1ps

module i2cebm_checker
    import i2cebm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // Requests taken but whose results are not yet delivered.
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (item_valid && item_ready && !(res_valid && res_ready))
        begin
            pending_next = 2'(pending_reg + 2'd1);
        end
        else if (!(item_valid && item_ready) && res_valid && res_ready)
        begin
            pending_next = 2'(pending_reg - 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result shown without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more requests in flight than the two stages hold");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done reported while still busy");

    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.done_res |-> res.read_data == 8'd0)
        else $error("read data shown outside the done tick");

endmodule

bind i2c_eeprom_byte_master_core i2cebm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
);

// ----- tb/i2c_eeprom_byte_master_core_tb.sv -----
`timescale 1ns / 1ps

import i2cebm_pkg::*;

// Actions of the bus sequencer. A transaction is a list of sub-sequences, and each
// sub-sequence is a list of these actions. Every tick runs the zero-time actions up to
// the next delay or ack poll, and that delay or poll consumes the tick; a zero wait poll does not.
typedef enum int {
    OP_SCL_LO,
    OP_SCL_HI,
    OP_SDA_LO,
    OP_SDA_HI,
    OP_SDA_BIT,
    OP_DELAY,
    OP_SAMPLE,
    OP_NEXT_BIT,
    OP_LOAD,
    OP_CLEAR,
    OP_ARM,
    OP_POLL,
    OP_RETURN
} bus_op_t;

class eeprom_bus_scoreboard;

    logic [7:0]  half_period = HALF_PERIOD_RESET;
    logic [15:0] ack_timeout = ACK_TIMEOUT_RESET;

    bit          in_transfer = 1'b0;
    int unsigned prog_pos = 0;
    int unsigned op_pos = 0;
    logic [7:0]  phase_cnt = '0;
    logic [3:0]  bits_done = '0;
    logic [7:0]  shifter = '0;
    logic [8:0]  addr_q = '0;
    logic [7:0]  data_q = '0;
    bit          read_xfer = 1'b0;
    logic [15:0] ack_wait = '0;
    logic        scl_q = 1'b0;
    logic        sda_q = 1'b1;

    res_t expected_levels[$];
    int   errors = 0;
    int   results_seen = 0;

    function int pending();
        return expected_levels.size();
    endfunction

    function void program_step(output sub_e_t sub, output src_e_t src);
        sub = SUB_END;
        src = SRC_DEV;
        if (read_xfer)
        begin
            case (prog_pos)
                0, 3: sub = SUB_START;
                1:    sub = SUB_WB;
                2:
                begin
                    sub = SUB_WB;
                    src = SRC_ADDR;
                end
                4:
                begin
                    sub = SUB_WB;
                    src = SRC_DEVR;
                end
                5:       sub = SUB_RB;
                6:       sub = SUB_NOACK;
                7:       sub = SUB_STOP;
                default: sub = SUB_END;
            endcase
        end
        else
        begin
            case (prog_pos)
                0: sub = SUB_START;
                1: sub = SUB_WB;
                2:
                begin
                    sub = SUB_WB;
                    src = SRC_ADDR;
                end
                3:
                begin
                    sub = SUB_WB;
                    src = SRC_DATA;
                end
                4:       sub = SUB_STOP;
                default: sub = SUB_END;
            endcase
        end
    endfunction

    function bus_op_t op_at(sub_e_t sub, int unsigned pos);
        bus_op_t seq[$];
        case (sub)
            SUB_START: seq = '{OP_SCL_LO, OP_SDA_HI, OP_DELAY, OP_SCL_HI, OP_DELAY, OP_SDA_LO,
                               OP_DELAY, OP_SCL_LO, OP_DELAY, OP_SDA_HI, OP_RETURN};
            SUB_WB:    seq = '{OP_LOAD, OP_SCL_LO, OP_DELAY, OP_SDA_BIT, OP_SCL_HI, OP_DELAY,
                               OP_NEXT_BIT, OP_SCL_LO, OP_DELAY, OP_SDA_HI, OP_DELAY,
                               OP_SCL_HI, OP_DELAY, OP_SCL_LO, OP_ARM, OP_DELAY, OP_POLL,
                               OP_RETURN};
            SUB_RB:    seq = '{OP_CLEAR, OP_SCL_LO, OP_SCL_HI, OP_DELAY, OP_SAMPLE, OP_DELAY,
                               OP_SCL_LO, OP_DELAY, OP_NEXT_BIT, OP_RETURN};
            SUB_NOACK: seq = '{OP_SCL_LO, OP_SDA_HI, OP_DELAY, OP_SCL_HI, OP_DELAY, OP_SCL_LO,
                               OP_DELAY, OP_RETURN};
            default:   seq = '{OP_SCL_LO, OP_DELAY, OP_SDA_LO, OP_DELAY, OP_SCL_HI, OP_DELAY,
                               OP_SDA_HI, OP_DELAY, OP_SCL_LO, OP_RETURN};
        endcase
        if (pos < seq.size())
            return seq[pos];
        return OP_RETURN;
    endfunction

    function logic [7:0] byte_for(src_e_t src);
        logic [7:0] dev;
        dev = DEV_BASE | {6'd0, addr_q[8], 1'b0};
        case (src)
            SRC_DEV:  return dev;
            SRC_DEVR: return dev | 8'h01;
            SRC_ADDR: return addr_q[7:0];
            default:  return data_q;
        endcase
    endfunction

    // True when the coming tick is the one that ends the transaction.
    function bit last_stop_tick();
        sub_e_t sub;
        src_e_t src;
        program_step(sub, src);
        return in_transfer && sub == SUB_STOP && op_pos == 8;
    endfunction

    function void advance(logic sda, output bit done);
        sub_e_t  sub;
        src_e_t  src;
        bus_op_t op;
        int      guard;
        done = 1'b0;
        for (guard = 0; guard < 256; guard++)
        begin
            program_step(sub, src);
            if (sub == SUB_END)
            begin
                in_transfer = 1'b0;
                done = 1'b1;
                return;
            end
            op = op_at(sub, op_pos);
            case (op)
                OP_SCL_LO:
                begin
                    scl_q = 1'b0;
                    op_pos++;
                end
                OP_SCL_HI:
                begin
                    scl_q = 1'b1;
                    op_pos++;
                end
                OP_SDA_LO:
                begin
                    sda_q = 1'b0;
                    op_pos++;
                end
                OP_SDA_HI:
                begin
                    sda_q = 1'b1;
                    op_pos++;
                end
                OP_SDA_BIT:
                begin
                    sda_q = shifter[7];
                    shifter = shifter << 1;
                    op_pos++;
                end
                OP_SAMPLE:
                begin
                    shifter = {shifter[6:0], sda};
                    op_pos++;
                end
                OP_NEXT_BIT:
                begin
                    bits_done++;
                    if (bits_done < 8)
                        op_pos = (sub == SUB_WB) ? 1 : 2;
                    else
                    begin
                        bits_done = '0;
                        op_pos++;
                    end
                end
                OP_LOAD:
                begin
                    shifter = byte_for(src);
                    bits_done = '0;
                    op_pos++;
                end
                OP_CLEAR:
                begin
                    shifter = '0;
                    bits_done = '0;
                    op_pos++;
                end
                OP_ARM:
                begin
                    ack_wait = ack_timeout;
                    op_pos++;
                end
                OP_DELAY:
                begin
                    phase_cnt = phase_cnt + 8'd1;
                    if (phase_cnt >= half_period)
                    begin
                        phase_cnt = '0;
                        op_pos++;
                    end
                    return;
                end
                OP_POLL:
                begin
                    if (ack_wait == 0)
                        op_pos++;
                    else
                    begin
                        if (sda)
                            op_pos++;
                        else
                        begin
                            ack_wait--;
                            if (ack_wait == 0)
                                op_pos++;
                        end
                        return;
                    end
                end
                default:
                begin
                    prog_pos++;
                    op_pos = 0;
                end
            endcase
        end
    endfunction

    function void note_request(item_t it);
        bit   done;
        res_t want;
        done = 1'b0;
        if (!in_transfer)
        begin
            if (it.req_type == REQ_READ || it.req_type == REQ_WRITE)
            begin
                addr_q = it.mem_addr;
                data_q = it.write_data;
                read_xfer = (it.req_type == REQ_READ);
                in_transfer = 1'b1;
                prog_pos = 0;
                op_pos = 0;
                phase_cnt = '0;
                bits_done = '0;
                ack_wait = '0;
                advance(it.sda_in, done);
            end
        end
        else
            advance(it.sda_in, done);
        want.scl_level = scl_q;
        want.sda_level = sda_q;
        want.busy_res = in_transfer;
        want.done_res = done;
        want.read_data = (done && read_xfer) ? shifter : 8'd0;
        expected_levels.push_back(want);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endfunction

    function void check_result(res_t got);
        res_t want;
        results_seen++;
        if (expected_levels.size() == 0)
        begin
            $error("bus levels %h arrived with no request outstanding", got);
            errors++;
            return;
        end
        want = expected_levels.pop_front();
        compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        compare_field("read_data", want.read_data, got.read_data);
    endfunction

endclass

module i2c_eeprom_byte_master_core_tb;

    // Request code that the block must treat like a plain tick.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Cycles without any handshake or register write before the run is declared hung.
    // The longest legal quiet stretch is the deliberate output hold-off below.
    localparam int QUIET_LIMIT = 2000;

    // The result receiver stops taking results for this many cycles once, after
    // HOLD_AFTER results, while requests keep coming, so the block backs up.
    localparam int HOLD_AFTER  = 250;
    localparam int HOLD_CYCLES = 120;

    // Window of requests (and of results on the other side) with no idling at all.
    localparam int BUSY_FROM = 500;
    localparam int BUSY_TO   = 700;

    localparam int N_SETTINGS = 7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;

    eeprom_bus_scoreboard sb = new();

    // Directed requests, issued one by one whenever the sequencer is idle.
    item_t opening[$];

    // How the testbench plays the EEPROM on SDA: 0 random, 1 mostly high (quick acks,
    // read bytes with many ones), 2 held low (ack timeouts and zero bits).
    int sda_mode;

    i2c_eeprom_byte_master_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    always #5 clk = ~clk;

    // Settings walked through in order: the shortest and longest bus phases, no ack
    // polling at all, the longest ack wait, a zero half period that must act like one,
    // and the reset values. Each entry also says how many live requests it gets.
    task automatic pick_setting(input int idx, output logic [7:0] hp, output logic [15:0] ack,
                                output int budget);
        case (idx)
            0:
            begin
                hp = 8'd1;   ack = 16'd0;     budget = 300;
            end
            1:
            begin
                hp = 8'd2;   ack = 16'd3;     budget = 150;
            end
            2:
            begin
                hp = 8'd255; ack = 16'hFFFF;  budget = 300;
            end
            3:
            begin
                hp = 8'd1;   ack = 16'hFFFF;  budget = 100;
            end
            4:
            begin
                hp = 8'd0;   ack = 16'd1;     budget = 100;
            end
            5:
            begin
                hp = HALF_PERIOD_RESET; ack = ACK_TIMEOUT_RESET; budget = 40;
            end
            default:
            begin
                hp = 8'd3;   ack = 16'd7;     budget = 100;
            end
        endcase
    endtask

    // One register write: setup phase, access phase, then the port goes quiet so that
    // back-to-back writes never touch psel twice in one step.
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] hp, input logic [15:0] ack);
        write_register({REG_HALF_PERIOD, 2'b00}, {24'd0, hp});
        write_register({REG_ACK_TIMEOUT, 2'b00}, {16'd0, ack});
        sb.half_period = hp;
        sb.ack_timeout = ack;
    endtask

    function automatic logic pick_sda();
        case (sda_mode)
            0:       return 1'($urandom_range(1, 0));
            1:       return $urandom_range(7, 0) != 0;
            default: return 1'b0;
        endcase
    endfunction

    // Builds the next request. An idle sequencer mostly gets a new read or write with
    // random address and data; a busy one mostly gets plain ticks. Start requests also
    // show up now and then while busy, and often on the tick that ends a transaction,
    // since both must be ignored.
    function automatic item_t make_tick();
        item_t it;
        int    roll;
        it.mem_addr   = 9'($urandom_range(511, 0));
        it.write_data = 8'($urandom_range(255, 0));
        it.sda_in     = pick_sda();
        it.req_type   = REQ_TICK;
        if (!sb.in_transfer)
        begin
            if (opening.size() > 0)
                return opening.pop_front();
            roll = $urandom_range(15, 0);
            if (roll < 7)
                it.req_type = REQ_READ;
            else if (roll < 14)
                it.req_type = REQ_WRITE;
            else if (roll == 14)
                it.req_type = REQ_TICK;
            else
                it.req_type = REQ_SPARE;
        end
        else if (sb.last_stop_tick() && $urandom_range(1, 0) == 1)
            it.req_type = $urandom_range(1, 0) ? REQ_READ : REQ_WRITE;
        else if ($urandom_range(31, 0) == 0)
        begin
            roll = $urandom_range(2, 0);
            it.req_type = (roll == 0) ? REQ_READ : (roll == 1) ? REQ_WRITE : REQ_SPARE;
        end
        return it;
    endfunction

    // Presents one request and returns at the falling edge after it was taken. The
    // valid stays high on return, so a request that follows at once needs no toggle.
    task automatic offer_item(input item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    // Stimulus: reset, then one block of requests per setting, each started only
    // after every expected result of the previous block has come back.
    initial
    begin
        item_t       it;
        logic [7:0]  hp;
        logic [15:0] ack;
        int          budget;
        int          live;
        int          sent;
        int          idx;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        item_valid = 1'b0;
        item       = '0;
        sda_mode   = 0;
        sent       = 0;

        // Field extremes, both EEPROM blocks, both directions, and the spare code.
        opening.push_back('{REQ_TICK,  9'h000, 8'h00, 1'b0});
        opening.push_back('{REQ_SPARE, 9'h1FF, 8'hFF, 1'b1});
        opening.push_back('{REQ_WRITE, 9'h1FF, 8'hFF, 1'b1});
        opening.push_back('{REQ_READ,  9'h000, 8'h00, 1'b0});
        opening.push_back('{REQ_WRITE, 9'h000, 8'h00, 1'b0});
        opening.push_back('{REQ_READ,  9'h1FF, 8'h5A, 1'b1});
        opening.push_back('{REQ_WRITE, 9'h0FF, 8'h80, 1'b1});
        opening.push_back('{REQ_READ,  9'h100, 8'h01, 1'b0});

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (idx = 0; idx < N_SETTINGS; idx++)
        begin
            item_valid <= 1'b0;
            while (sb.pending() != 0)
                @(negedge clk);
            pick_setting(idx, hp, ack, budget);
            apply_setting(hp, ack);
            live = 0;
            while (live < budget)
            begin
                if ((sent < BUSY_FROM || sent >= BUSY_TO) && $urandom_range(99, 0) < 6)
                begin
                    item_valid <= 1'b0;
                    @(negedge clk);
                end
                else
                begin
                    if ($urandom_range(39, 0) == 0)
                        sda_mode = $urandom_range(2, 0);
                    it = make_tick();
                    // Idle ticks that start nothing do not count toward the budget.
                    if (sb.in_transfer || it.req_type == REQ_READ || it.req_type == REQ_WRITE)
                        live++;
                    offer_item(it);
                    sent++;
                end
            end
        end

        // Drain, then keep watching so that any stray result can still show up.
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("i2c_eeprom_byte_master_core: match");
        else
            $display("i2c_eeprom_byte_master_core: mismatch");
        $finish;
    end

    // Result receiver: random stalls, a stretch with none, and one long hold-off.
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if ((sb.results_seen < BUSY_FROM || sb.results_seen >= BUSY_TO)
                     && $urandom_range(99, 0) < 6)
                res_ready <= 1'b0;
            else
                res_ready <= 1'b1;
        end
    end

    // Both handshakes are sampled at the rising edge. A result taken in the same cycle
    // as a request belongs to an earlier request, so it is checked first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
                sb.check_result(res);
            if (item_valid && item_ready)
                sb.note_request(item);
        end
    end

    // Watchdog on progress: any handshake or register access restarts the count.
    always @(posedge clk)
    begin
        int quiet_cycles;
        if ((item_valid && item_ready) || (res_valid && res_ready) || (psel && penable))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("i2c_eeprom_byte_master_core: mismatch");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
rtl/i2cebm_pkg.sv
rtl/i2cebm_cfg.sv
rtl/i2cebm_seq.sv
rtl/i2c_eeprom_byte_master_core.sv
rtl/i2cebm_checker.sv
tb/i2c_eeprom_byte_master_core_tb.sv
